// ===== hw/rtl/bops_pkg.sv =====
// ----------------------------------------------------------------------------
// bops_pkg
// shared widths, record reset values and the path weight table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bops_pkg;

  localparam int TT_W    = 64;
  localparam int ORD_W   = 3;
  localparam int CNT_W   = 6;
  localparam int REC_W   = 7;
  localparam int POWER_W = 24;
  localparam int WGT_W   = 18;

  localparam logic [REC_W-1:0]   REC_COUNT_RESET = REC_W'(64);
  localparam logic [POWER_W-1:0] POWER_ALL_ONES  = {POWER_W{1'b1}};

  // 10 * 1.25^k with 12 fraction bits, k = path length in nodes
  function automatic logic [WGT_W-1:0] path_weight(input logic [2:0] k);
    logic [WGT_W-1:0] w;
    case (k)
      3'd0:    w = WGT_W'(40960);
      3'd1:    w = WGT_W'(51200);
      3'd2:    w = WGT_W'(64000);
      3'd3:    w = WGT_W'(80000);
      3'd4:    w = WGT_W'(100000);
      3'd5:    w = WGT_W'(125000);
      default: w = WGT_W'(156250);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/bops_if.sv =====
// ----------------------------------------------------------------------------
// bops_in_if / bops_out_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bops_in_if
  import bops_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TT_W-1:0]  truth_table;
  logic [ORD_W-1:0] order_level0;
  logic [ORD_W-1:0] order_level1;
  logic [ORD_W-1:0] order_level2;
  logic [ORD_W-1:0] order_level3;
  logic [ORD_W-1:0] order_level4;
  logic [ORD_W-1:0] order_level5;
  logic             restart;

  modport source (
    output valid, truth_table, order_level0, order_level1, order_level2,
           order_level3, order_level4, order_level5, restart,
    input  ready
  );
  modport sink (
    input  valid, truth_table, order_level0, order_level1, order_level2,
           order_level3, order_level4, order_level5, restart,
    output ready
  );
endinterface

interface bops_out_if
  import bops_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   node_count;
  logic [POWER_W-1:0] path_power;
  logic [REC_W-1:0]   fewest_nodes;
  logic [POWER_W-1:0] fewest_nodes_power;
  logic [POWER_W-1:0] least_power;
  logic [REC_W-1:0]   least_power_nodes;

  modport source (
    output valid, node_count, path_power, fewest_nodes, fewest_nodes_power,
           least_power, least_power_nodes,
    input  ready
  );
  modport sink (
    input  valid, node_count, path_power, fewest_nodes, fewest_nodes_power,
           least_power, least_power_nodes,
    output ready
  );
endinterface

// ===== hw/rtl/bops_ram.sv =====
// ----------------------------------------------------------------------------
// bops_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bops_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/bdd_order_size_power_eval.sv =====
// ----------------------------------------------------------------------------
// bdd_order_size_power_eval
// size and path power of a reduced ordered decision diagram, with best records
// ----------------------------------------------------------------------------
// in_ch carries one beat per function: truth table, per-level order, restart.
// out_ch returns one beat per item: node count, path power and the two best
// records (fewest nodes, least power) after this item.
// in_ch.ready is high only while the sequencer is idle; one item at a time.
// steps per item, n = NUM_VARS:
//   build  writes every node of the full tree, one tree node written per cycle
//   reduce merges redundant and duplicate nodes level by level, using the
//          single compare unit reading one earlier node per cycle
//   walk   visits the nodes depth first through the child ram
//   finish loads the result and both records into the output register
// a finished result sits in the output register; the next item is taken
// while it waits, and the sequencer stalls at finish only if the old result
// is still not taken then.
// reset (rst_n low, synchronous) empties the output, idles the sequencer and
// sets both records to 64 nodes / all-ones power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdd_order_size_power_eval
  import bops_pkg::*;
#(
  parameter int NUM_VARS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  bops_in_if.sink    in_ch,
  bops_out_if.source out_ch
);

  localparam int NODE_W    = NUM_VARS;
  localparam int CW        = NUM_VARS + 1;
  localparam int NUM_NODES = 1 << NUM_VARS;
  localparam int LEAF_BASE = 1 << (NUM_VARS - 1);
  localparam int LVL_W     = $clog2(NUM_VARS);
  localparam int DEP_W     = $clog2(NUM_VARS + 1);
  localparam int STK_D     = NUM_VARS;
  localparam int SP_W      = $clog2(STK_D + 1);
  localparam int SI_W      = $clog2(STK_D);

  // child codes: node index, or a terminal just above the node range
  localparam logic [CW-1:0] T_FALSE = CW'(NUM_NODES);
  localparam logic [CW-1:0] T_TRUE  = CW'(NUM_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_BUILD, S_RV, S_VD, S_CMP, S_WRD, S_WDAT, S_FIN
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DEP_W-1:0]  depth;
  } stk_t;

  state_t state_r;

  // latched item
  logic [NUM_NODES-1:0] tt_r;
  logic [ORD_W-1:0]     ord_r [NUM_VARS];
  logic                 restart_r;
  logic [ORD_W-1:0]     in_ord [6];

  // reduction sequencer
  logic [NODE_W-1:0] v_r;
  logic [NODE_W-1:0] u_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [CW-1:0]     l_r;
  logic [CW-1:0]     r_r;

  // walk
  logic [NODE_W-1:0]    cur_r;
  logic [DEP_W-1:0]     dep_r;
  stk_t                 stk_r [STK_D];
  logic [SP_W-1:0]      sp_r;
  logic [NODE_W-1:0]    cnt_r;
  logic [POWER_W-1:0]   pw_r;

  // records
  logic [REC_W-1:0]   bn_cnt_r;
  logic [POWER_W-1:0] bn_pw_r;
  logic [POWER_W-1:0] bp_pw_r;
  logic [REC_W-1:0]   bp_cnt_r;

  // ram ports
  logic              we_l, we_r, we_v;
  logic [NODE_W-1:0] waddr;
  logic [CW-1:0]     wdata_l, wdata_r;
  logic [0:0]        wdata_v;
  logic [NODE_W-1:0] raddr;
  logic [CW-1:0]     rd_l, rd_r;
  logic [0:0]        rd_v;

  bops_ram #(.WIDTH(CW), .DEPTH(NUM_NODES)) u_ram_l (
    .clk(clk), .we(we_l), .waddr(waddr), .wdata(wdata_l),
    .raddr(raddr), .rdata(rd_l)
  );
  bops_ram #(.WIDTH(CW), .DEPTH(NUM_NODES)) u_ram_r (
    .clk(clk), .we(we_r), .waddr(waddr), .wdata(wdata_r),
    .raddr(raddr), .rdata(rd_r)
  );
  // visit marks: cleared while the tree is built, set on the first visit
  bops_ram #(.WIDTH(1), .DEPTH(NUM_NODES)) u_ram_v (
    .clk(clk), .we(we_v), .waddr(waddr), .wdata(wdata_v),
    .raddr(raddr), .rdata(rd_v)
  );

  assign in_ord[0] = in_ch.order_level0;
  assign in_ord[1] = in_ch.order_level1;
  assign in_ord[2] = in_ch.order_level2;
  assign in_ord[3] = in_ch.order_level3;
  assign in_ord[4] = in_ch.order_level4;
  assign in_ord[5] = in_ch.order_level5;

  assign in_ch.ready = (state_r == S_IDLE);
  wire in_beat = in_ch.valid && in_ch.ready;

  // level bounds
  logic [NODE_W-1:0] base, last;
  assign base = NODE_W'(1) << lvl_r;
  assign last = base + (base - NODE_W'(1));

  // leaf construction: truth-table index from the path bits of the leaf
  logic [NODE_W-1:0] sel [NUM_VARS];
  logic [NODE_W-1:0] idx, ridx;
  logic [NODE_W-2:0] leaf_m;
  always_comb begin
    for (int i = 0; i < NUM_VARS; i++) begin
      sel[i] = (ord_r[i] < ORD_W'(NUM_VARS)) ? (NODE_W'(1) << ord_r[i]) : '0;
    end
    leaf_m = v_r[NODE_W-2:0];
    idx = '0;
    for (int i = 0; i < NUM_VARS - 1; i++) begin
      if (leaf_m[NUM_VARS-2-i]) idx = idx | sel[i];
    end
    ridx = idx | sel[NUM_VARS-1];
  end

  // compare unit
  wire l_eq_r   = (rd_l == rd_r);
  wire cmp_hit  = (rd_l == l_r) && (rd_r == r_r);
  wire v_is_top = (v_r == NODE_W'(1));

  // walk datapath
  logic             l_walk, r_walk, l_true, r_true;
  logic [WGT_W-1:0] wgt;
  logic [WGT_W:0]   pw_add;
  logic [POWER_W:0] pw_sum;
  logic [POWER_W-1:0] pw_sat;
  wire  deep_ok = (dep_r < DEP_W'(NUM_VARS));
  always_comb begin
    l_true = (rd_l == T_TRUE);
    r_true = (rd_r == T_TRUE);
    l_walk = !rd_l[CW-1] && (rd_l[NODE_W-1:0] != '0) && deep_ok;
    r_walk = !rd_r[CW-1] && (rd_r[NODE_W-1:0] != '0) && deep_ok;
    wgt    = path_weight(3'(dep_r));
    case ({l_true, r_true})
      2'b11:   pw_add = {wgt, 1'b0};
      2'b10,
      2'b01:   pw_add = {1'b0, wgt};
      default: pw_add = '0;
    endcase
    pw_sum = {1'b0, pw_r} + (POWER_W+1)'(pw_add);
    pw_sat = pw_sum[POWER_W] ? POWER_ALL_ONES : pw_sum[POWER_W-1:0];
  end

  wire [SI_W-1:0] push_idx = SI_W'(sp_r);
  wire [SI_W-1:0] top_idx  = SI_W'(sp_r - SP_W'(1));

  // ram port control
  always_comb begin
    we_l    = 1'b0;
    we_r    = 1'b0;
    we_v    = 1'b0;
    waddr   = v_r;
    wdata_l = '0;
    wdata_r = '0;
    wdata_v = 1'b0;
    raddr   = v_r;
    case (state_r)
      S_BUILD: begin
        we_l = 1'b1;
        we_r = 1'b1;
        we_v = 1'b1;
        if (v_r < NODE_W'(LEAF_BASE)) begin
          wdata_l = CW'({v_r, 1'b0});
          wdata_r = CW'({v_r, 1'b1});
        end else begin
          wdata_l = tt_r[idx]  ? T_TRUE : T_FALSE;
          wdata_r = tt_r[ridx] ? T_TRUE : T_FALSE;
        end
      end
      S_VD: begin
        // redundant node: parent bypasses it
        waddr   = v_r >> 1;
        wdata_l = rd_l;
        wdata_r = rd_l;
        if (l_eq_r && !v_is_top) begin
          we_l = !v_r[0];
          we_r = v_r[0];
        end
        raddr = base;
      end
      S_CMP: begin
        // duplicate node: parent points at the earlier twin
        waddr   = v_r >> 1;
        wdata_l = CW'(u_r);
        wdata_r = CW'(u_r);
        if (cmp_hit && !v_is_top) begin
          we_l = !v_r[0];
          we_r = v_r[0];
        end
        raddr = u_r + NODE_W'(1);
      end
      S_WRD:   raddr = cur_r;
      S_WDAT: begin
        // mark the node on its first visit
        waddr   = cur_r;
        wdata_v = 1'b1;
        we_v    = !rd_v[0];
      end
      default: raddr = v_r;
    endcase
  end

  // records after this item
  logic [REC_W-1:0]   bn_c0, bp_c0, wn, bn_c1, bp_c1;
  logic [POWER_W-1:0] bn_p0, bp_p0, bn_p1, bp_p1;
  always_comb begin
    bn_c0 = restart_r ? REC_COUNT_RESET : bn_cnt_r;
    bn_p0 = restart_r ? POWER_ALL_ONES  : bn_pw_r;
    bp_p0 = restart_r ? POWER_ALL_ONES  : bp_pw_r;
    bp_c0 = restart_r ? REC_COUNT_RESET : bp_cnt_r;
    wn    = REC_W'(cnt_r);
    bn_c1 = bn_c0;
    bn_p1 = bn_p0;
    bp_p1 = bp_p0;
    bp_c1 = bp_c0;
    if (wn < bn_c0 || (wn == bn_c0 && pw_r < bn_p0)) begin
      bn_c1 = wn;
      bn_p1 = pw_r;
    end
    if (pw_r < bp_p0 || (pw_r == bp_p0 && wn < bp_c0)) begin
      bp_p1 = pw_r;
      bp_c1 = wn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_ch.valid <= 1'b0;
      bn_cnt_r     <= REC_COUNT_RESET;
      bn_pw_r      <= POWER_ALL_ONES;
      bp_pw_r      <= POWER_ALL_ONES;
      bp_cnt_r     <= REC_COUNT_RESET;
      sp_r         <= '0;
    end else begin
      // finish reloads the output register itself
      if (out_ch.valid && out_ch.ready && state_r != S_FIN) begin
        out_ch.valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            tt_r      <= in_ch.truth_table[NUM_NODES-1:0];
            restart_r <= in_ch.restart;
            for (int i = 0; i < NUM_VARS; i++) begin
              ord_r[i] <= in_ord[i];
            end
            v_r     <= NODE_W'(1);
            state_r <= S_BUILD;
          end
        end
        S_BUILD: begin
          if (v_r == NODE_W'(NUM_NODES - 1)) begin
            lvl_r   <= LVL_W'(NUM_VARS - 1);
            v_r     <= NODE_W'(LEAF_BASE);
            state_r <= S_RV;
          end else begin
            v_r <= v_r + NODE_W'(1);
          end
        end
        S_RV: begin
          state_r <= S_VD;
        end
        S_VD, S_CMP: begin
          logic done_v;
          done_v = 1'b0;
          if (state_r == S_VD) begin
            l_r <= rd_l;
            r_r <= rd_r;
            if (l_eq_r || v_r == base) begin
              done_v = 1'b1;
            end else begin
              u_r     <= base;
              state_r <= S_CMP;
            end
          end else if (cmp_hit || (u_r + NODE_W'(1)) == v_r) begin
            done_v = 1'b1;
          end else begin
            u_r <= u_r + NODE_W'(1);
          end
          if (done_v) begin
            if (v_r != last) begin
              v_r     <= v_r + NODE_W'(1);
              state_r <= S_RV;
            end else if (lvl_r != '0) begin
              lvl_r   <= lvl_r - LVL_W'(1);
              v_r     <= base >> 1;
              state_r <= S_RV;
            end else begin
              // start the walk at the root, depth one
              cur_r   <= NODE_W'(1);
              dep_r   <= DEP_W'(1);
              sp_r    <= '0;
              cnt_r   <= '0;
              pw_r    <= '0;
              state_r <= S_WRD;
            end
          end
        end
        S_WRD: begin
          state_r <= S_WDAT;
        end
        S_WDAT: begin
          if (!rd_v[0]) begin
            cnt_r <= cnt_r + NODE_W'(1);
          end
          pw_r    <= pw_sat;
          state_r <= S_WRD;
          if (l_walk) begin
            cur_r <= rd_l[NODE_W-1:0];
            dep_r <= dep_r + DEP_W'(1);
            if (r_walk) begin
              stk_r[push_idx] <= '{node: rd_r[NODE_W-1:0], depth: dep_r + DEP_W'(1)};
              sp_r            <= sp_r + SP_W'(1);
            end
          end else if (r_walk) begin
            cur_r <= rd_r[NODE_W-1:0];
            dep_r <= dep_r + DEP_W'(1);
          end else if (sp_r != '0) begin
            cur_r <= stk_r[top_idx].node;
            dep_r <= stk_r[top_idx].depth;
            sp_r  <= sp_r - SP_W'(1);
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid              <= 1'b1;
            out_ch.node_count         <= CNT_W'(cnt_r);
            out_ch.path_power         <= pw_r;
            out_ch.fewest_nodes       <= bn_c1;
            out_ch.fewest_nodes_power <= bn_p1;
            out_ch.least_power        <= bp_p1;
            out_ch.least_power_nodes  <= bp_c1;
            bn_cnt_r                  <= bn_c1;
            bn_pw_r                   <= bn_p1;
            bp_pw_r                   <= bp_p1;
            bp_cnt_r                  <= bp_c1;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
